@@ design/sawarq_pkg.sv @@
`default_nettype none

package sawarq_pkg;

  // Request codes
  localparam logic [1:0] REQ_SEND = 2'd0;
  localparam logic [1:0] REQ_RX   = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // Event codes
  localparam logic [2:0] EV_TX     = 3'd0;
  localparam logic [2:0] EV_DELIV  = 3'd1;
  localparam logic [2:0] EV_FAIL   = 3'd2;
  localparam logic [2:0] EV_ACKED  = 3'd3;
  localparam logic [2:0] EV_REJECT = 3'd4;

  // Configuration register indexes
  localparam int          CFG_IDX_W      = 2;
  localparam int          CFG_DATA_W     = 16;
  localparam logic [1:0]  CFG_MY_ADDR    = 2'd0;
  localparam logic [1:0]  CFG_BCAST_ADDR = 2'd1;
  localparam logic [1:0]  CFG_MAX_ATT    = 2'd2;
  localparam logic [1:0]  CFG_ACK_TMO    = 2'd3;

  // Configuration reset values
  localparam logic [7:0]  MY_ADDR_RST    = 8'hff;
  localparam logic [7:0]  BCAST_ADDR_RST = 8'hff;
  localparam logic [3:0]  MAX_ATT_RST    = 4'd3;
  localparam logic [15:0] ACK_TMO_RST    = 16'd1000;

  localparam int SEND_QUEUE_DEPTH_DEF = 8;

  // Result queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_IDX_W = 2;
  localparam int OQ_CNT_W = 3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] dest_address;
    logic       new_id;
    logic [7:0] rx_to;
    logic [7:0] rx_from;
    logic [7:0] rx_id;
    logic       rx_is_ack;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] frame_to;
    logic [7:0] frame_from;
    logic [7:0] frame_id;
    logic       frame_is_ack;
    logic       last_result;
  } out_item_t;

  // Results of one transaction handed to the result queue
  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } res_push_t;

endpackage

`default_nettype wire

@@ design/sawarq_ram.sv @@
`default_nettype none

module sawarq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, and read with new data forwarded on an address match
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ design/sawarq_ctrl.sv @@
`default_nettype none

module sawarq_ctrl
  import sawarq_pkg::*;
#(
  parameter int SEND_QUEUE_DEPTH = SEND_QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_fire,
  input  wire in_item_t              in_item,
  output res_push_t                  push
);

  localparam int QI_W   = (SEND_QUEUE_DEPTH > 1) ? $clog2(SEND_QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(SEND_QUEUE_DEPTH + 1);
  localparam int SUM_W  = FILL_W + 1;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(SEND_QUEUE_DEPTH);
  localparam logic [QI_W-1:0]   HEAD_LAST = QI_W'(SEND_QUEUE_DEPTH - 1);
  localparam logic [SUM_W-1:0]  SUM_DEPTH = SUM_W'(SEND_QUEUE_DEPTH);

  // Configuration registers
  logic [7:0]  my_addr_r, bcast_addr_r;
  logic [3:0]  max_att_r;
  logic [15:0] ack_tmo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_addr_r    <= MY_ADDR_RST;
      bcast_addr_r <= BCAST_ADDR_RST;
      max_att_r    <= MAX_ATT_RST;
      ack_tmo_r    <= ACK_TMO_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MY_ADDR:    my_addr_r    <= cfg_wdata[7:0];
        CFG_BCAST_ADDR: bcast_addr_r <= cfg_wdata[7:0];
        CFG_MAX_ATT:    max_att_r    <= cfg_wdata[3:0];
        CFG_ACK_TMO:    ack_tmo_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Link state
  logic [7:0]        seq_r, seq_nxt;
  logic              await_r, await_nxt;
  logic [7:0]        pend_dest_r, pend_dest_nxt;
  logic [7:0]        pend_id_r, pend_id_nxt;
  logic [3:0]        att_r, att_nxt;
  logic [15:0]       timer_r, timer_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [QI_W-1:0]   head_r, head_nxt;

  // Send queue storage
  logic              q_we;
  logic [QI_W-1:0]   q_waddr;
  logic [15:0]       q_wdata, q_rdata;
  logic [SUM_W-1:0]  tail_sum;
  logic [15:0]       timer_dec;
  logic [7:0]        seq_inc;

  sawarq_ram #(
    .WIDTH(16),
    .DEPTH(SEND_QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (q_we),
    .waddr(q_waddr),
    .wdata(q_wdata),
    .raddr(head_nxt),
    .rdata(q_rdata)
  );

  assign tail_sum  = SUM_W'(head_r) + SUM_W'(fill_r);
  assign q_waddr   = (tail_sum >= SUM_DEPTH) ? QI_W'(tail_sum - SUM_DEPTH) : QI_W'(tail_sum);
  assign timer_dec = (timer_r != 16'd0) ? (timer_r - 16'd1) : 16'd0;
  assign seq_inc   = seq_r + {7'd0, in_item.new_id};

  // Decide the results and next state of one transaction
  always_comb begin
    seq_nxt       = seq_r;
    await_nxt     = await_r;
    pend_dest_nxt = pend_dest_r;
    pend_id_nxt   = pend_id_r;
    att_nxt       = att_r;
    timer_nxt     = timer_r;
    fill_nxt      = fill_r;
    head_nxt      = head_r;
    q_we          = 1'b0;
    q_wdata       = {in_item.dest_address, seq_inc};
    push          = '0;

    if (in_fire) begin
      case (in_item.req_type)
        REQ_SEND: begin
          seq_nxt = seq_inc;
          if (!await_r) begin
            pend_dest_nxt = in_item.dest_address;
            pend_id_nxt   = seq_inc;
            await_nxt     = 1'b1;
            att_nxt       = 4'd1;
            timer_nxt     = ack_tmo_r;
            push.n        = 2'd1;
            push.r0       = '{EV_TX, in_item.dest_address, my_addr_r, seq_inc, 1'b0, 1'b1};
          end else if (fill_r < FILL_MAX) begin
            q_we     = 1'b1;
            fill_nxt = fill_r + FILL_W'(1);
          end else begin
            push.n  = 2'd1;
            push.r0 = '{EV_REJECT, in_item.dest_address, my_addr_r, seq_inc, 1'b0, 1'b1};
          end
        end
        REQ_RX: begin
          if (in_item.rx_to == my_addr_r) begin
            if (in_item.rx_is_ack) begin
              if (await_r) begin
                if (in_item.rx_from == pend_dest_r && in_item.rx_id == pend_id_r) begin
                  await_nxt = 1'b0;
                  push.n    = 2'd1;
                  push.r0   = '{EV_ACKED, pend_dest_r, my_addr_r, pend_id_r, 1'b0, 1'b1};
                end else begin
                  timer_nxt = ack_tmo_r;
                  push.n    = 2'd1;
                  push.r0   = '{EV_TX, pend_dest_r, my_addr_r, pend_id_r, 1'b0, 1'b1};
                end
              end
            end else begin
              push.n  = 2'd2;
              push.r0 = '{EV_DELIV, in_item.rx_to, in_item.rx_from, in_item.rx_id,
                          1'b0, 1'b0};
              push.r1 = '{EV_TX, in_item.rx_from, my_addr_r, in_item.rx_id, 1'b1, 1'b1};
            end
          end else if (in_item.rx_to == bcast_addr_r) begin
            push.n  = 2'd1;
            push.r0 = '{EV_DELIV, in_item.rx_to, in_item.rx_from, in_item.rx_id,
                        1'b0, 1'b1};
          end
        end
        REQ_TICK: begin
          if (await_r) begin
            timer_nxt = timer_dec;
            if (timer_dec == 16'd0) begin
              if (att_r >= max_att_r) begin
                await_nxt = 1'b0;
                push.n    = 2'd1;
                push.r0   = '{EV_FAIL, pend_dest_r, my_addr_r, pend_id_r, 1'b0, 1'b1};
              end else begin
                att_nxt   = att_r + 4'd1;
                timer_nxt = ack_tmo_r;
                push.n    = 2'd1;
                push.r0   = '{EV_TX, pend_dest_r, my_addr_r, pend_id_r, 1'b0, 1'b1};
              end
            end
          end
        end
        default: ;
      endcase

      // Start the next queued frame after a completed or failed send
      if (await_r && !await_nxt && fill_r != '0) begin
        await_nxt     = 1'b1;
        pend_dest_nxt = q_rdata[15:8];
        pend_id_nxt   = q_rdata[7:0];
        att_nxt       = 4'd1;
        timer_nxt     = ack_tmo_r;
        fill_nxt      = fill_r - FILL_W'(1);
        head_nxt      = (head_r == HEAD_LAST) ? '0 : head_r + QI_W'(1);
        push.n        = 2'd2;
        push.r0.last_result = 1'b0;
        push.r1       = '{EV_TX, q_rdata[15:8], my_addr_r, q_rdata[7:0], 1'b0, 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= '0;
      await_r     <= 1'b0;
      pend_dest_r <= '0;
      pend_id_r   <= '0;
      att_r       <= '0;
      timer_r     <= '0;
      fill_r      <= '0;
      head_r      <= '0;
    end else begin
      seq_r       <= seq_nxt;
      await_r     <= await_nxt;
      pend_dest_r <= pend_dest_nxt;
      pend_id_r   <= pend_id_nxt;
      att_r       <= att_nxt;
      timer_r     <= timer_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
    end
  end

  // Queue holds frames only behind a frame awaiting its ACK
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !await_r |-> (fill_r == '0))
    else $error("send queue not empty while idle");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("send queue overfilled");

  a_att_live: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> (att_r != 4'd0))
    else $error("awaiting ACK with zero attempts");

endmodule

`default_nettype wire

@@ design/sawarq_outq.sv @@
`default_nettype none

module sawarq_outq
  import sawarq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire res_push_t push,
  output logic           space_ok,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  out_item_t           buf_r [OQ_DEPTH];
  logic [OQ_IDX_W-1:0] wr_r, rd_r;
  logic [OQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_data  = buf_r[rd_r];
  assign space_ok  = (cnt_r <= OQ_CNT_W'(OQ_DEPTH - 2));
  assign cnt_nxt   = cnt_r + OQ_CNT_W'(push.n) - OQ_CNT_W'(pop);

  // Store up to two results per transaction
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      buf_r[wr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      buf_r[wr_r + OQ_IDX_W'(1)] <= push.r1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + OQ_IDX_W'(push.n);
      rd_r  <= rd_r + OQ_IDX_W'(pop);
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> space_ok)
    else $error("results pushed without room");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && push.n == 2'd0) |=> (cnt_r == $past(cnt_r) - OQ_CNT_W'(1)))
    else $error("result count wrong after pop");

endmodule

`default_nettype wire

@@ design/stop_and_wait_arq_link.sv @@
// Results: written into the 4-entry result queue and offered on out_ from there.
// Throughput: one input transaction per cycle while that queue has room for two
// results; a second result of the same transaction is offered after the first.
// Reset: synchronous, active low; clears link state, queue counters and restores
// configuration defaults. Queue storage is not cleared.
`default_nettype none

module stop_and_wait_arq_link
  import sawarq_pkg::*;
#(
  parameter int SEND_QUEUE_DEPTH = SEND_QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data
);

  res_push_t push;
  logic      in_fire;

  // Accept a transaction whenever the result queue has room for two results
  assign in_fire = in_valid && in_ready;

  sawarq_ctrl #(
    .SEND_QUEUE_DEPTH(SEND_QUEUE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_fire  (in_fire),
    .in_item  (in_data),
    .push     (push)
  );

  sawarq_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space_ok (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

@@ dv/stop_and_wait_arq_link_tb.sv @@
`default_nettype none

module stop_and_wait_arq_link_tb;
  import sawarq_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int SQ_DEPTH = SEND_QUEUE_DEPTH_DEF;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 225;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  stop_and_wait_arq_link dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Link requests waiting for the driver, and link events still owed by the block
  in_item_t link_reqs[$];
  out_item_t due_events[$];
  out_item_t want_ev;
  int items_sent = 0;
  int n_err = 0;
  int stall_cycles = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_cnt = 0;

  // Shadow of the configuration registers
  logic [7:0] own_addr = MY_ADDR_RST;
  logic [7:0] bcast_addr = BCAST_ADDR_RST;
  logic [3:0] max_tx = MAX_ATT_RST;
  logic [15:0] ack_wait = ACK_TMO_RST;

  // Shadow of the link state
  logic [7:0] seq_ctr = '0;
  logic link_busy = 1'b0;
  logic [7:0] cur_dest = '0;
  logic [7:0] cur_id = '0;
  logic [3:0] tx_count = '0;
  logic [15:0] wait_left = '0;
  logic [15:0] sq_mem [SQ_DEPTH];
  int sq_fill = 0;
  int sq_head = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic out_item_t make_event(logic [2:0] kind, logic [7:0] to, logic [7:0] from,
                                           logic [7:0] id, logic ack);
    out_item_t e;
    e.event_kind = kind;
    e.frame_to = to;
    e.frame_from = from;
    e.frame_id = id;
    e.frame_is_ack = ack;
    e.last_result = 1'b0;
    return e;
  endfunction

  // Send the outstanding frame again and restart the ACK wait
  function automatic out_item_t resend_frame();
    wait_left = ack_wait;
    return make_event(EV_TX, cur_dest, own_addr, cur_id, 1'b0);
  endfunction

  function automatic out_item_t open_frame(logic [7:0] dest, logic [7:0] id);
    cur_dest = dest;
    cur_id = id;
    link_busy = 1'b1;
    tx_count = 4'd1;
    return resend_frame();
  endfunction

  function automatic bit pop_next_frame(output out_item_t ev);
    logic [15:0] e;
    ev = '0;
    if (sq_fill == 0) return 1'b0;
    e = sq_mem[sq_head];
    sq_head = (sq_head + 1) % SQ_DEPTH;
    sq_fill--;
    ev = open_frame(e[15:8], e[7:0]);
    return 1'b1;
  endfunction

  // Advance the link shadow by one request and queue the events it owes
  function automatic void link_step(in_item_t it);
    out_item_t r [2];
    int n;
    n = 0;
    case (it.req_type)
      REQ_SEND: begin
        if (it.new_id) seq_ctr = seq_ctr + 8'd1;
        if (!link_busy) begin
          r[0] = open_frame(it.dest_address, seq_ctr);
          n = 1;
        end else if (sq_fill < SQ_DEPTH) begin
          sq_mem[(sq_head + sq_fill) % SQ_DEPTH] = {it.dest_address, seq_ctr};
          sq_fill++;
        end else begin
          r[0] = make_event(EV_REJECT, it.dest_address, own_addr, seq_ctr, 1'b0);
          n = 1;
        end
      end
      REQ_RX: begin
        if (it.rx_to == own_addr) begin
          if (!it.rx_is_ack) begin
            r[0] = make_event(EV_DELIV, it.rx_to, it.rx_from, it.rx_id, 1'b0);
            r[1] = make_event(EV_TX, it.rx_from, own_addr, it.rx_id, 1'b1);
            n = 2;
          end else if (link_busy) begin
            if (it.rx_from == cur_dest && it.rx_id == cur_id) begin
              r[0] = make_event(EV_ACKED, cur_dest, own_addr, cur_id, 1'b0);
              link_busy = 1'b0;
              n = 1 + pop_next_frame(r[1]);
            end else begin
              r[0] = resend_frame();
              n = 1;
            end
          end
        end else if (it.rx_to == bcast_addr) begin
          r[0] = make_event(EV_DELIV, it.rx_to, it.rx_from, it.rx_id, 1'b0);
          n = 1;
        end
      end
      REQ_TICK: begin
        if (link_busy) begin
          if (wait_left != 16'd0) wait_left = wait_left - 16'd1;
          if (wait_left == 16'd0) begin
            if (tx_count >= max_tx) begin
              r[0] = make_event(EV_FAIL, cur_dest, own_addr, cur_id, 1'b0);
              link_busy = 1'b0;
              n = 1 + pop_next_frame(r[1]);
            end else begin
              tx_count = tx_count + 4'd1;
              r[0] = resend_frame();
              n = 1;
            end
          end
        end
      end
      default: ;
    endcase
    if (n > 0) r[n-1].last_result = 1'b1;
    for (int i = 0; i < n; i++) due_events.push_back(r[i]);
  endfunction

  // Drive the request channel
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (link_reqs.size() != 0 && (no_idle || $urandom_range(99) >= 12)) begin
        in_valid <= 1'b1;
        in_data <= link_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Drive ready on the event channel; hold off once for a long stretch on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_cnt <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || $urandom_range(99) >= 12;
    end
  end

  // Predict on each accepted request, check each accepted event, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) link_step(in_data);
      if (out_valid && out_ready) begin
        if (due_events.size() == 0) begin
          $error("unexpected event: event_kind %0d frame_id %0h",
                 out_data.event_kind, out_data.frame_id);
          n_err++;
        end else begin
          want_ev = due_events.pop_front();
          if (out_data.event_kind !== want_ev.event_kind) begin
            $error("event_kind: expected %0d, actual %0d", want_ev.event_kind,
                   out_data.event_kind);
            n_err++;
          end
          if (out_data.frame_to !== want_ev.frame_to) begin
            $error("frame_to: expected %0h, actual %0h", want_ev.frame_to, out_data.frame_to);
            n_err++;
          end
          if (out_data.frame_from !== want_ev.frame_from) begin
            $error("frame_from: expected %0h, actual %0h", want_ev.frame_from,
                   out_data.frame_from);
            n_err++;
          end
          if (out_data.frame_id !== want_ev.frame_id) begin
            $error("frame_id: expected %0h, actual %0h", want_ev.frame_id, out_data.frame_id);
            n_err++;
          end
          if (out_data.frame_is_ack !== want_ev.frame_is_ack) begin
            $error("frame_is_ack: expected %0b, actual %0b", want_ev.frame_is_ack,
                   out_data.frame_is_ack);
            n_err++;
          end
          if (out_data.last_result !== want_ev.last_result) begin
            $error("last_result: expected %0b, actual %0b", want_ev.last_result,
                   out_data.last_result);
            n_err++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic in_item_t rand_item();
    in_item_t it;
    it.req_type = 2'($urandom);
    it.dest_address = 8'($urandom);
    it.new_id = 1'($urandom);
    it.rx_to = 8'($urandom);
    it.rx_from = 8'($urandom);
    it.rx_id = 8'($urandom);
    it.rx_is_ack = 1'($urandom);
    return it;
  endfunction

  function automatic void queue_item(in_item_t it);
    link_reqs.push_back(it);
    if (it.req_type != REQ_NONE) items_sent++;
  endfunction

  function automatic void queue_send(logic [7:0] dest, logic fresh);
    in_item_t it;
    it = rand_item();
    it.req_type = REQ_SEND;
    it.dest_address = dest;
    it.new_id = fresh;
    queue_item(it);
  endfunction

  function automatic void queue_rx(logic [7:0] to, logic [7:0] from, logic [7:0] id,
                                   logic ack);
    in_item_t it;
    it = rand_item();
    it.req_type = REQ_RX;
    it.rx_to = to;
    it.rx_from = from;
    it.rx_id = id;
    it.rx_is_ack = ack;
    queue_item(it);
  endfunction

  function automatic void queue_bare(logic [1:0] req);
    in_item_t it;
    it = rand_item();
    it.req_type = req;
    queue_item(it);
  endfunction

  // Background traffic: frames for us, broadcasts, stray headers, ticks, unused codes, sends
  function automatic void queue_noise();
    case ($urandom_range(5))
      0: queue_rx(own_addr, 8'($urandom), 8'($urandom), 1'b0);
      1: queue_rx(bcast_addr, 8'($urandom), 8'($urandom), 1'($urandom));
      2: queue_bare(REQ_RX);
      3: queue_bare(REQ_NONE);
      4: queue_bare(REQ_TICK);
      default: queue_bare(REQ_SEND);
    endcase
  endfunction

  // One exchange: a few sends, then ticks and ACKs for each outstanding frame in order
  task automatic gen_session();
    logic [15:0] frames[$];
    logic [15:0] fr;
    logic [7:0] seq;
    logic [7:0] dest;
    logic fresh;
    int k;
    int i;
    if (link_busy) frames.push_back({cur_dest, cur_id});
    for (i = 0; i < sq_fill; i++) frames.push_back(sq_mem[(sq_head + i) % SQ_DEPTH]);
    seq = seq_ctr;
    k = ($urandom_range(7) == 0) ? $urandom_range(10, 6) : $urandom_range(3);
    for (i = 0; i < k; i++) begin
      dest = 8'($urandom);
      fresh = 1'($urandom);
      if (fresh) seq = seq + 8'd1;
      if (frames.size() < SQ_DEPTH + 1) frames.push_back({dest, seq});
      queue_send(dest, fresh);
      if ($urandom_range(4) == 0) queue_noise();
    end
    while (frames.size() != 0) begin
      fr = frames.pop_front();
      repeat (($urandom_range(5) == 0) ? $urandom_range(12) : $urandom_range(2))
        queue_bare(REQ_TICK);
      if ($urandom_range(4) == 0) begin
        if ($urandom_range(1) == 0)
          queue_rx(own_addr, fr[15:8], fr[7:0] ^ (8'($urandom) | 8'h01), 1'b1);
        else
          queue_rx(own_addr, fr[15:8] ^ (8'($urandom) | 8'h80), fr[7:0], 1'b1);
      end
      if ($urandom_range(9) != 0) queue_rx(own_addr, fr[15:8], fr[7:0], 1'b1);
      if ($urandom_range(3) == 0) queue_noise();
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  // Write all registers, with junk in the unused upper bits, and update the shadow
  task automatic apply_cfg(logic [7:0] own, logic [7:0] bc, logic [3:0] att,
                           logic [15:0] tmo);
    logic [CFG_DATA_W-1:0] v0;
    logic [CFG_DATA_W-1:0] v1;
    logic [CFG_DATA_W-1:0] v2;
    v0 = {8'($urandom), own};
    v1 = {8'($urandom), bc};
    v2 = {12'($urandom), att};
    write_reg(CFG_MY_ADDR, v0);
    write_reg(CFG_BCAST_ADDR, v1);
    write_reg(CFG_MAX_ATT, v2);
    write_reg(CFG_ACK_TMO, tmo);
    @(posedge clk);
    cfg_we <= 1'b0;
    own_addr = v0[7:0];
    bcast_addr = v1[7:0];
    max_tx = v2[3:0];
    ack_wait = tmo;
    @(negedge clk);
  endtask

  task automatic wait_taken();
    @(negedge clk);
    while (link_reqs.size() != 0 || in_valid) @(negedge clk);
  endtask

  // Wait until every request is taken and every event seen, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    while (link_reqs.size() != 0 || in_valid || due_events.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int target;
    logic [7:0] a;
    logic [7:0] b;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset addresses: own equals broadcast, so the frame is ours and gets ACKed
    queue_rx(8'hFF, 8'h21, 8'h42, 1'b0);
    settle();

    apply_cfg(8'h3C, 8'hC3, 4'd2, 16'd2);
    // Idle: tick, unused code and ACK all do nothing
    queue_bare(REQ_TICK);
    queue_bare(REQ_NONE);
    queue_rx(8'h3C, 8'h12, 8'h34, 1'b1);
    // Send, queue one, stray ACK, wrong ACK, right ACK starts the queued frame
    queue_send(8'h00, 1'b1);
    queue_send(8'hFF, 1'b0);
    queue_rx(8'h11, 8'h00, 8'h01, 1'b1);
    queue_rx(8'h3C, 8'h00, 8'h09, 1'b1);
    queue_rx(8'h3C, 8'h00, 8'h01, 1'b1);
    // Retransmit on the first timeout, fail on the second
    repeat (4) queue_bare(REQ_TICK);
    // Delivery paths: ours, broadcast, broadcast carrying the ACK marker
    queue_rx(8'h3C, 8'h77, 8'hAA, 1'b0);
    queue_rx(8'hC3, 8'h80, 8'h55, 1'b0);
    queue_rx(8'hC3, 8'h00, 8'hFF, 1'b1);
    // Fill the send queue, then overflow it with a fresh id
    queue_send(8'hA5, 1'b1);
    for (int i = 0; i < SQ_DEPTH; i++) queue_send(8'(i * 37), 1'(i));
    queue_send(8'h5A, 1'b1);
    settle();

    // Zero timeout and zero attempts: once the running wait ends, each tick fails a
    // frame and starts the next
    apply_cfg(8'h00, 8'h00, 4'd0, 16'd0);
    repeat (4) queue_bare(REQ_TICK);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_cfg(8'hFF, 8'h00, 4'd15, 16'hFFFF);
        1: apply_cfg(8'h00, 8'hFF, 4'd1, 16'd1);
        default: begin
          a = 8'($urandom);
          b = ($urandom_range(3) == 0) ? a : 8'($urandom);
          apply_cfg(a, b, ($urandom_range(7) == 0) ? 4'd0 : 4'($urandom_range(15, 1)),
                    16'($urandom_range(8)));
        end
      endcase
      no_idle = (ph == 2);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        gen_session();
        wait_taken();
      end
      if (ph == 4) begin
        // Stall the event side while frames for us keep arriving
        hold_req = 1'b1;
        repeat (60) queue_rx(own_addr, 8'($urandom), 8'($urandom), 1'b0);
      end
      settle();
    end

    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
